>>> rtl/idtfp_pkg.sv
// Shared types, constants, and the known frame id table for the ID3v2 frame parser.
package idtfp_pkg;

  localparam int unsigned ROM_COUNT   = 98;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_DESC = 2'd0,
    KIND_PAY  = 2'd1,
    KIND_STOP = 2'd2
  } item_kind_e;

  typedef enum logic [2:0] {
    CAUSE_NO_TAG    = 3'd0,
    CAUSE_TAG_FLAGS = 3'd1,
    CAUSE_TAG_SIZE  = 3'd2,
    CAUSE_FRM_SIZE  = 3'd3,
    CAUSE_TAG_END   = 3'd4,
    CAUSE_PADDING   = 3'd5
  } stop_cause_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [2:0]  version;
    logic [31:0] code;
    logic [6:0]  index;
    logic [31:0] plen;
    logic [15:0] flags;
    logic [7:0]  pbyte;
    logic        fend;
    stop_cause_e cause;
  } result_t;

  function automatic logic [27:0] syncsafe(input logic [31:0] w);
    return {w[30:24], w[22:16], w[14:8], w[6:0]};
  endfunction

  function automatic logic [31:0] id3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return {a, b, c, 8'h00};
  endfunction

  function automatic logic [31:0] id4(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [7:0] d);
    return {a, b, c, d};
  endfunction

  function automatic logic [31:0] id_rom(input logic [6:0] i);
    logic [31:0] r;
    unique case (i)
      7'd0:  r = id3("T","T","1");  7'd1:  r = id3("T","T","2");
      7'd2:  r = id3("T","T","3");  7'd3:  r = id3("T","P","1");
      7'd4:  r = id3("T","P","2");  7'd5:  r = id3("T","P","3");
      7'd6:  r = id3("T","P","4");  7'd7:  r = id3("T","C","M");
      7'd8:  r = id3("T","X","T");  7'd9:  r = id3("T","L","A");
      7'd10: r = id3("T","C","O");  7'd11: r = id3("T","A","L");
      7'd12: r = id3("T","P","A");  7'd13: r = id3("T","R","K");
      7'd14: r = id3("T","R","C");  7'd15: r = id3("T","Y","E");
      7'd16: r = id3("T","R","D");  7'd17: r = id3("T","M","T");
      7'd18: r = id3("T","F","T");  7'd19: r = id3("T","B","P");
      7'd20: r = id3("T","C","R");  7'd21: r = id3("T","P","B");
      7'd22: r = id3("T","E","N");  7'd23: r = id3("T","S","S");
      7'd24: r = id3("T","O","F");  7'd25: r = id3("T","L","E");
      7'd26: r = id3("T","S","I");  7'd27: r = id3("T","O","T");
      7'd28: r = id3("T","O","A");  7'd29: r = id3("T","O","L");
      7'd30: r = id3("T","O","R");  7'd31: r = id3("W","A","F");
      7'd32: r = id3("W","A","R");  7'd33: r = id3("W","A","S");
      7'd34: r = id3("W","C","M");  7'd35: r = id3("W","C","P");
      7'd36: r = id3("W","C","B");  7'd37: r = id3("I","P","L");
      7'd38: r = id3("U","L","T");  7'd39: r = id3("S","L","T");
      7'd40: r = id3("C","O","M");  7'd41: r = id3("P","I","C");
      7'd42: r = id4("T","A","L","B"); 7'd43: r = id4("T","B","P","M");
      7'd44: r = id4("T","C","O","M"); 7'd45: r = id4("T","C","O","N");
      7'd46: r = id4("T","C","O","P"); 7'd47: r = id4("T","D","A","T");
      7'd48: r = id4("T","E","N","C"); 7'd49: r = id4("T","E","X","T");
      7'd50: r = id4("T","F","L","T"); 7'd51: r = id4("T","I","T","1");
      7'd52: r = id4("T","I","T","2"); 7'd53: r = id4("T","I","T","3");
      7'd54: r = id4("T","L","A","N"); 7'd55: r = id4("T","L","E","N");
      7'd56: r = id4("T","M","E","D"); 7'd57: r = id4("T","O","A","L");
      7'd58: r = id4("T","O","F","N"); 7'd59: r = id4("T","O","L","Y");
      7'd60: r = id4("T","O","P","E"); 7'd61: r = id4("T","O","R","Y");
      7'd62: r = id4("T","O","W","N"); 7'd63: r = id4("T","P","E","1");
      7'd64: r = id4("T","P","E","2"); 7'd65: r = id4("T","P","E","3");
      7'd66: r = id4("T","P","E","4"); 7'd67: r = id4("T","P","O","S");
      7'd68: r = id4("T","P","U","B"); 7'd69: r = id4("T","R","C","K");
      7'd70: r = id4("T","R","S","N"); 7'd71: r = id4("T","S","I","Z");
      7'd72: r = id4("T","S","R","C"); 7'd73: r = id4("T","Y","E","R");
      7'd74: r = id4("W","C","O","M"); 7'd75: r = id4("W","C","O","P");
      7'd76: r = id4("W","O","A","F"); 7'd77: r = id4("W","O","A","S");
      7'd78: r = id4("W","O","R","S"); 7'd79: r = id4("W","P","A","Y");
      7'd80: r = id4("W","P","U","B"); 7'd81: r = id4("W","X","X","X");
      7'd82: r = id4("I","P","L","S"); 7'd83: r = id4("U","S","L","T");
      7'd84: r = id4("S","Y","L","T"); 7'd85: r = id4("C","O","M","M");
      7'd86: r = id4("A","P","I","C"); 7'd87: r = id4("L","I","N","K");
      7'd88: r = id4("U","S","E","R"); 7'd89: r = id4("T","D","O","R");
      7'd90: r = id4("T","I","P","L"); 7'd91: r = id4("T","M","C","L");
      7'd92: r = id4("T","M","O","O"); 7'd93: r = id4("T","P","R","O");
      7'd94: r = id4("T","S","O","A"); 7'd95: r = id4("T","S","O","P");
      7'd96: r = id4("T","S","O","T"); 7'd97: r = id4("T","S","S","T");
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/id3v2_tag_frame_parser_unit.sv
// Top level of the ID3v2 tag frame parser: front parser, result queue, output stage.
// The block takes one file byte per cycle from offset zero and gives at most one
// result word per byte: a frame descriptor, a payload byte, or one final stop word.
// Bytes are accepted back to back; the front parser stalls only when its
// four-word result queue is full, which happens only while the consumer stalls.
// A result is written into the queue and then into the output register before it
// appears on the outputs. file_length must be written while idle.
module id3v2_tag_frame_parser_unit #(
  parameter int unsigned KNOWN_FRAMES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  item_kind_o,
  output logic [2:0]  tag_version_o,
  output logic [31:0] frame_code_o,
  output logic [6:0]  known_index_o,
  output logic [31:0] payload_length_o,
  output logic [15:0] frame_flag_bits_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_end_o,
  output logic [2:0]  stop_cause_o
);
  import idtfp_pkg::*;

  logic    acc, emit, push, pop, q_empty, q_full;
  result_t front_rec, q_rec, out_rec;

  // a word is taken whenever the queue has room for its possible result
  assign in_stall_o = q_full;
  assign acc        = in_valid_i && !in_stall_o;
  assign push       = emit;

  idtfp_front #(.KNOWN_FRAMES(KNOWN_FRAMES)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .acc_i(acc), .byte_i(file_byte_i), .emit_o(emit), .rec_o(front_rec)
  );

  idtfp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(front_rec), .pop_i(pop),
    .rdata_o(q_rec), .empty_o(q_empty), .full_o(q_full)
  );

  idtfp_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(q_rec), .pop_o(pop),
    .out_stall_i, .out_valid_o, .out_o(out_rec)
  );

  assign item_kind_o       = out_rec.kind;
  assign tag_version_o     = out_rec.version;
  assign frame_code_o      = out_rec.code;
  assign known_index_o     = out_rec.index;
  assign payload_length_o  = out_rec.plen;
  assign frame_flag_bits_o = out_rec.flags;
  assign payload_byte_o    = out_rec.pbyte;
  assign frame_end_o       = out_rec.fend;
  assign stop_cause_o      = out_rec.cause;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full && !pop)) else $error("result queue overflow");
  a_emit_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> acc) else $error("result without an accepted word");
  a_stop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && front_rec.kind == KIND_STOP) |=> !push) else $error("result after stop");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty) else $error("pop from empty queue");
`endif

endmodule

>>> rtl/idtfp_front.sv
// Front end: byte-level tag and frame header parser that emits result words.
module idtfp_front #(
  parameter int unsigned KNOWN_FRAMES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              acc_i,
  input  logic [7:0]        byte_i,
  output logic              emit_o,
  output idtfp_pkg::result_t rec_o
);
  import idtfp_pkg::*;

  typedef enum logic [7:0] {
    PH_TAG  = 8'b0000_0001,
    PH_EXT3 = 8'b0000_0010,
    PH_EXT4 = 8'b0000_0100,
    PH_FHDR = 8'b0000_1000,
    PH_DROP = 8'b0001_0000,
    PH_PAY  = 8'b0010_0000,
    PH_SKIP = 8'b0100_0000,
    PH_STOP = 8'b1000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] shift_q, shift_d;
  logic [31:0] pos_q, pos_d;
  logic [27:0] tl_q, tl_d;
  logic [2:0]  ver_q, ver_d;
  logic        ext_q, ext_d;
  logic [31:0] bl_q, bl_d;
  logic [15:0] flags_q, flags_d;
  logic [31:0] code_q, code_d;
  logic [6:0]  idx_q, idx_d;
  logic        hit_q, hit_d;
  logic [6:0]  hidx_q, hidx_d;
  logic [31:0] flen_q;

  // id lookup over the constant table, done when the id bytes are complete
  logic [31:0] cand;
  logic        lk_hit;
  logic [6:0]  lk_idx;
  logic [31:0] rom_w;
  logic        three;

  always_comb begin
    three  = (ver_q == 3'd2);
    cand   = three ? {shift_q[15:0], byte_i, 8'h00} : {shift_q[23:0], byte_i};
    lk_hit = 1'b0;
    lk_idx = '0;
    rom_w  = '0;
    for (int i = ROM_COUNT - 1; i >= 0; i--) begin
      rom_w = id_rom(7'(i));
      if ((i < KNOWN_FRAMES) && (rom_w == cand) && ((rom_w[7:0] == 8'h00) == three)) begin
        lk_hit = 1'b1;
        lk_idx = 7'(i);
      end
    end
  end

  logic [31:0] low, csize, rem, skip_n;
  logic [27:0] ss;
  logic [3:0]  hl;
  logic [2:0]  dropped;
  logic [15:0] fl;

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; shift_d = shift_q; pos_d = pos_q;
    tl_d = tl_q; ver_d = ver_q; ext_d = ext_q; bl_d = bl_q; flags_d = flags_q;
    code_d = code_q; idx_d = idx_q; hit_d = hit_q; hidx_d = hidx_q;
    emit_o = 1'b0;
    rec_o = '0;
    rec_o.version = ver_q;
    low = {shift_q[23:0], byte_i};
    ss = syncsafe(low);
    hl = three ? 4'd6 : 4'd10;
    csize = '0; rem = '0; skip_n = '0; dropped = '0; fl = '0;
    if (acc_i && phase_q != PH_STOP) begin
      shift_d = {shift_q[55:0], byte_i};
      pos_d   = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
      unique case (phase_q)
        PH_TAG: begin
          if ((cnt_q == 4'd0 && byte_i != 8'h49) || (cnt_q == 4'd1 && byte_i != 8'h44) ||
              (cnt_q == 4'd2 && byte_i != 8'h33) ||
              (cnt_q == 4'd3 && (byte_i < 8'd2 || byte_i > 8'd4))) begin
            emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_NO_TAG;
            phase_d = PH_STOP;
          end else if (cnt_q == 4'd5 && ver_q != 3'd2 && (byte_i & 8'hA0) != 8'h00) begin
            emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_TAG_FLAGS;
            phase_d = PH_STOP;
          end else if (cnt_q < 4'd9) begin
            if (cnt_q == 4'd3) ver_d = byte_i[2:0];
            if (cnt_q == 4'd5 && ver_q != 3'd2) ext_d = byte_i[6];
            cnt_d = cnt_q + 4'd1;
          end else begin
            tl_d = ss;
            if ({5'd0, ss} + 33'd10 > {1'b0, flen_q}) begin
              emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_TAG_SIZE;
              phase_d = PH_STOP;
            end else begin
              cnt_d = '0;
              if (ext_q && ver_q == 3'd3)      phase_d = PH_EXT3;
              else if (ext_q && ver_q == 3'd4) phase_d = PH_EXT4;
              else                             phase_d = PH_FHDR;
            end
          end
        end
        PH_EXT3: begin
          if (cnt_q == 4'd3) bl_d = low;
          if (cnt_q < 4'd9) begin
            cnt_d = cnt_q + 4'd1;
          end else if (low < {4'd0, tl_q}) begin
            tl_d = tl_q - low[27:0];
            skip_n = (bl_q > 32'd6) ? bl_q - 32'd6 : 32'd0;
            cnt_d = '0; bl_d = skip_n;
            phase_d = (skip_n != 32'd0) ? PH_SKIP : PH_FHDR;
          end else begin
            emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_PADDING;
            phase_d = PH_STOP;
          end
        end
        PH_EXT4: begin
          if (cnt_q < 4'd3) begin
            cnt_d = cnt_q + 4'd1;
          end else begin
            skip_n = (ss > 28'd4) ? {4'd0, ss - 28'd4} : 32'd0;
            cnt_d = '0; bl_d = skip_n;
            phase_d = (skip_n != 32'd0) ? PH_SKIP : PH_FHDR;
          end
        end
        PH_FHDR: begin
          if (cnt_q == 4'd0 && (({1'b0, pos_q} + {29'd0, hl} >= {5'd0, tl_q} + 33'd10) ||
                                byte_i == 8'h00)) begin
            emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_TAG_END;
            phase_d = PH_STOP;
          end else begin
            if ((three && cnt_q == 4'd2) || (!three && cnt_q == 4'd3)) begin
              code_d = cand; hit_d = lk_hit; hidx_d = lk_idx;
            end
            if (cnt_q < hl - 4'd1) begin
              cnt_d = cnt_q + 4'd1;
            end else begin
              cnt_d = '0;
              if (three) begin
                csize = {8'd0, low[23:0]};
                fl = '0;
              end else begin
                csize = shift_d[47:16];
                if (ver_q == 3'd4) csize = {4'd0, syncsafe(shift_d[47:16])};
                fl = low[15:0];
              end
              flags_d = fl;
              if (ver_q == 3'd3 && fl[5]) dropped = 3'd1;
              if (ver_q == 3'd4) dropped = 3'(fl[6]) + (fl[0] ? 3'd4 : 3'd0);
              if (csize == 32'd0 || ({1'b0, pos_q} + 33'd1 + {1'b0, csize} > {1'b0, flen_q}))
              begin
                emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_FRM_SIZE;
                phase_d = PH_STOP;
              end else if ((ver_q == 3'd3 && (fl & 16'h00C0) != 16'h0) ||
                           (ver_q == 3'd4 && (fl & 16'h000E) != 16'h0) || !hit_q) begin
                bl_d = csize; phase_d = PH_SKIP;
              end else if (csize <= {29'd0, dropped}) begin
                emit_o = 1'b1; rec_o.kind = KIND_STOP; rec_o.cause = CAUSE_FRM_SIZE;
                phase_d = PH_STOP;
              end else begin
                idx_d = hidx_q;
                bl_d  = csize - {29'd0, dropped};
                cnt_d = {1'b0, dropped};
                phase_d = (dropped != 3'd0) ? PH_DROP : PH_PAY;
                emit_o = 1'b1;
                rec_o.kind  = KIND_DESC;
                rec_o.code  = code_q;
                rec_o.index = hidx_q;
                rec_o.plen  = csize - {29'd0, dropped};
                rec_o.flags = fl;
              end
            end
          end
        end
        PH_DROP: begin
          if (cnt_q <= 4'd1) begin
            cnt_d = '0; phase_d = PH_PAY;
          end else begin
            cnt_d = cnt_q - 4'd1;
          end
        end
        PH_PAY: begin
          rem = (bl_q != 32'd0) ? bl_q - 32'd1 : 32'd0;
          bl_d = rem;
          emit_o = 1'b1;
          rec_o.kind  = KIND_PAY;
          rec_o.code  = code_q;
          rec_o.index = idx_q;
          rec_o.flags = flags_q;
          rec_o.pbyte = byte_i;
          rec_o.fend  = (rem == 32'd0);
          if (rem == 32'd0) begin
            cnt_d = '0; phase_d = PH_FHDR;
          end
        end
        PH_SKIP: begin
          rem = (bl_q != 32'd0) ? bl_q - 32'd1 : 32'd0;
          bl_d = rem;
          if (rem == 32'd0) begin
            cnt_d = '0; phase_d = PH_FHDR;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG; cnt_q <= '0; shift_q <= '0; pos_q <= '0; tl_q <= '0;
      ver_q <= '0; ext_q <= 1'b0; bl_q <= '0; flags_q <= '0; code_q <= '0;
      idx_q <= '0; hit_q <= 1'b0; hidx_q <= '0; flen_q <= 32'hFFFF_FFFF;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; shift_q <= shift_d; pos_q <= pos_d;
      tl_q <= tl_d; ver_q <= ver_d; ext_q <= ext_d; bl_q <= bl_d; flags_q <= flags_d;
      code_q <= code_d; idx_q <= idx_d; hit_q <= hit_d; hidx_q <= hidx_d;
      if (cfg_we_i) flen_q <= cfg_wdata_i;
    end
  end

endmodule

>>> rtl/idtfp_queue.sv
// Short result queue between the parser and the output stage.
module idtfp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  idtfp_pkg::result_t wdata_i,
  input  logic               pop_i,
  output idtfp_pkg::result_t rdata_o,
  output logic               empty_o,
  output logic               full_o
);
  import idtfp_pkg::*;

  result_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_q, rp_q;
  logic [QPTR_W:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QPTR_W'(1);
      if (pop_i)  rp_q <= rp_q + QPTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + (QPTR_W+1)'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - (QPTR_W+1)'(1);
    end
  end

endmodule

>>> rtl/idtfp_back.sv
// Back end: output register that hands result words to the consumer.
module idtfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  idtfp_pkg::result_t q_data_i,
  output logic               pop_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output idtfp_pkg::result_t out_o
);
  import idtfp_pkg::*;

  logic    vld_q;
  result_t rec_q;

  assign pop_o       = !q_empty_i && (!vld_q || !out_stall_i);
  assign out_valid_o = vld_q;
  assign out_o       = rec_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= q_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      vld_q <= 1'b0;
    end
  end

endmodule

>>> verif/id3_frame_checker.sv
// Checker for the ID3v2 frame parser: byte-level predictor and result scoreboard.
`timescale 1ns / 100ps

module id3_frame_checker #(
  parameter int unsigned KNOWN_FRAMES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  item_kind_o,
  input  logic [2:0]  tag_version_o,
  input  logic [31:0] frame_code_o,
  input  logic [6:0]  known_index_o,
  input  logic [31:0] payload_length_o,
  input  logic [15:0] frame_flag_bits_o,
  input  logic [7:0]  payload_byte_o,
  input  logic        frame_end_o,
  input  logic [2:0]  stop_cause_o,
  output int          err_cnt_o,
  output int          pend_cnt_o
);
  import idtfp_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG, PH_EXT3, PH_EXT4, PH_FHDR, PH_DROP, PH_PAY, PH_SKIP, PH_DONE
  } phase_e;

  logic [31:0] flen;
  phase_e      phase;
  logic [3:0]  fcnt;
  logic [63:0] hshift;
  logic [31:0] pos;
  logic [31:0] tag_len;
  logic [2:0]  ver;
  logic        has_ext;
  logic [31:0] left;
  logic [15:0] cur_flags;
  logic [31:0] cur_code;
  logic [6:0]  cur_idx;
  result_t     exp_words[$];

  function automatic logic [31:0] unsync(input logic [31:0] w);
    return {4'd0, w[30:24], w[22:16], w[14:8], w[6:0]};
  endfunction

  function automatic result_t word(input item_kind_e k, input logic [31:0] code,
                                   input logic [6:0] idx, input logic [31:0] plen,
                                   input logic [15:0] fl, input logic [7:0] pb,
                                   input logic fe, input stop_cause_e c);
    result_t r;
    r.kind = k; r.version = ver; r.code = code; r.index = idx; r.plen = plen;
    r.flags = fl; r.pbyte = pb; r.fend = fe; r.cause = c;
    return r;
  endfunction

  // -1 when the id is not in the enabled part of the table
  function automatic int find_id(input logic [31:0] code, input logic three);
    logic [31:0] e;
    for (int i = 0; i < ROM_COUNT && i < KNOWN_FRAMES; i++) begin
      e = id_rom(7'(i));
      if (e == code && ((e[7:0] == 8'd0) == three)) return i;
    end
    return -1;
  endfunction

  task automatic start_skip(input logic [31:0] n);
    fcnt = 0;
    left = n;
    phase = (n != 0) ? PH_SKIP : PH_FHDR;
  endtask

  task automatic halt(input stop_cause_e c, output bit got, output result_t r);
    phase = PH_DONE;
    r = word(KIND_STOP, 0, 0, 0, 0, 0, 0, c);
    got = 1;
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit got, output result_t r);
    logic [31:0] p, lo, hl, csz, rem;
    logic [15:0] fl;
    logic [3:0]  c, drop;
    int          idx;
    got = 0;
    r = '0;
    if (phase == PH_DONE) return;
    p = pos;
    c = fcnt;
    hshift = {hshift[55:0], b};
    lo = hshift[31:0];
    if (pos != 32'hFFFF_FFFF) pos++;
    case (phase)
      PH_TAG: begin
        if ((c == 0 && b != 8'h49) || (c == 1 && b != 8'h44) || (c == 2 && b != 8'h33)) begin
          halt(CAUSE_NO_TAG, got, r);
          return;
        end
        if (c == 3) begin
          if (b < 2 || b > 4) begin
            halt(CAUSE_NO_TAG, got, r);
            return;
          end
          ver = b[2:0];
        end
        if (c == 5 && ver != 3'd2) begin
          if (b & 8'hA0) begin
            halt(CAUSE_TAG_FLAGS, got, r);
            return;
          end
          has_ext = b[6];
        end
        if (c < 9) begin
          fcnt = c + 1;
          return;
        end
        tag_len = unsync(lo);
        if (64'(tag_len) + 10 > 64'(flen)) begin
          halt(CAUSE_TAG_SIZE, got, r);
          return;
        end
        fcnt = 0;
        if (has_ext && ver == 3'd3) phase = PH_EXT3;
        else if (has_ext && ver == 3'd4) phase = PH_EXT4;
        else phase = PH_FHDR;
      end
      PH_EXT3: begin
        if (c == 3) left = lo;
        if (c < 9) begin
          fcnt = c + 1;
          return;
        end
        // padding size comes off the tag length
        if (lo < tag_len) begin
          tag_len -= lo;
        end else begin
          halt(CAUSE_PADDING, got, r);
          return;
        end
        start_skip(left > 6 ? left - 6 : 0);
      end
      PH_EXT4: begin
        if (c < 3) begin
          fcnt = c + 1;
          return;
        end
        csz = unsync(lo);
        start_skip(csz > 4 ? csz - 4 : 0);
      end
      PH_FHDR: begin
        hl = (ver == 3'd2) ? 6 : 10;
        if (c == 0 && (64'(p) + hl >= 64'(tag_len) + 10 || b == 8'd0)) begin
          halt(CAUSE_TAG_END, got, r);
          return;
        end
        if (ver == 3'd2 && c == 2) cur_code = {lo[23:0], 8'd0};
        if (ver != 3'd2 && c == 3) cur_code = lo;
        if (c < hl - 1) begin
          fcnt = c + 1;
          return;
        end
        fcnt = 0;
        if (ver == 3'd2) begin
          csz = {8'd0, lo[23:0]};
          fl = 0;
        end else begin
          csz = hshift[47:16];
          if (ver == 3'd4) csz = unsync(csz);
          fl = lo[15:0];
        end
        cur_flags = fl;
        if (csz == 0 || 64'(p) + 1 + csz > 64'(flen)) begin
          halt(CAUSE_FRM_SIZE, got, r);
          return;
        end
        // compressed / encrypted / unsynced frames are passed over
        if ((ver == 3'd3 && (fl & 16'h00C0)) || (ver == 3'd4 && (fl & 16'h000E))) begin
          start_skip(csz);
          return;
        end
        idx = find_id(cur_code, ver == 3'd2);
        if (idx < 0) begin
          start_skip(csz);
          return;
        end
        drop = 0;
        if (ver == 3'd3 && fl[5]) drop = 1;
        if (ver == 3'd4) drop = (fl[6] ? 4'd1 : 4'd0) + (fl[0] ? 4'd4 : 4'd0);
        if (csz <= drop) begin
          halt(CAUSE_FRM_SIZE, got, r);
          return;
        end
        cur_idx = 7'(idx);
        left = csz - drop;
        fcnt = drop;
        phase = (drop != 0) ? PH_DROP : PH_PAY;
        r = word(KIND_DESC, cur_code, cur_idx, left, fl, 0, 0, CAUSE_NO_TAG);
        got = 1;
      end
      PH_DROP: begin
        if (c <= 1) begin
          fcnt = 0;
          phase = PH_PAY;
        end else begin
          fcnt = c - 1;
        end
      end
      PH_PAY: begin
        rem = (left != 0) ? left - 1 : 0;
        left = rem;
        r = word(KIND_PAY, cur_code, cur_idx, 0, cur_flags, b, rem == 0, CAUSE_NO_TAG);
        got = 1;
        if (rem == 0) begin
          fcnt = 0;
          phase = PH_FHDR;
        end
      end
      default: begin
        rem = (left != 0) ? left - 1 : 0;
        left = rem;
        if (rem == 0) begin
          fcnt = 0;
          phase = PH_FHDR;
        end
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    err_cnt_o++;
  endtask

  assign pend_cnt_o = exp_words.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bit      got;
    result_t r, e;
    if (!rst_ni) begin
      flen = 32'hFFFF_FFFF; phase = PH_TAG; fcnt = 0; hshift = 0; pos = 0;
      tag_len = 0; ver = 0; has_ext = 0; left = 0; cur_flags = 0; cur_code = 0;
      cur_idx = 0;
      exp_words.delete();
      err_cnt_o = 0;
    end else begin
      if (cfg_we_i) flen = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) begin
        parse_byte(file_byte_i, got, r);
        if (got) exp_words.push_back(r);
      end
      if (out_valid_o && !out_stall_i) begin
        if (exp_words.size() == 0) begin
          report("unexpected word", {30'd0, item_kind_o}, 0);
        end else begin
          e = exp_words.pop_front();
          if (item_kind_o != e.kind) report("item_kind", 32'(item_kind_o), 32'(e.kind));
          if (tag_version_o != e.version) report("tag_version", 32'(tag_version_o), 32'(e.version));
          if (frame_code_o != e.code) report("frame_code", frame_code_o, e.code);
          if (known_index_o != e.index) report("known_index", 32'(known_index_o), 32'(e.index));
          if (payload_length_o != e.plen) report("payload_length", payload_length_o, e.plen);
          if (frame_flag_bits_o != e.flags) begin
            report("frame_flag_bits", 32'(frame_flag_bits_o), 32'(e.flags));
          end
          if (payload_byte_o != e.pbyte) report("payload_byte", 32'(payload_byte_o), 32'(e.pbyte));
          if (frame_end_o != e.fend) report("frame_end", 32'(frame_end_o), 32'(e.fend));
          if (stop_cause_o != e.cause) report("stop_cause", 32'(stop_cause_o), 32'(e.cause));
        end
      end
    end
  end

endmodule

>>> verif/tb.sv
// Testbench top for the ID3v2 frame parser: byte stream stimulus, handshake idling, verdict.
`timescale 1ns / 100ps

module tb;
  import idtfp_pkg::*;

  localparam int WDOG_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int DRAIN_WAIT = 12;    // margin past the queue and output register
  localparam int NUM_BYTES  = 1350;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  file_byte = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [1:0]  item_kind;
  logic [2:0]  tag_version;
  logic [31:0] frame_code;
  logic [6:0]  known_index;
  logic [31:0] payload_length;
  logic [15:0] frame_flag_bits;
  logic [7:0]  payload_byte;
  logic        frame_end;
  logic [2:0]  stop_cause;
  int          err_cnt, pend_cnt;

  // stimulus bookkeeping
  logic [2:0]  ver;
  logic [31:0] file_pos = 0;   // offset of the next byte we send
  logic [31:0] flen = 32'hFFFF_FFFF;
  bit          send_burst = 0, recv_burst = 0;
  bit          hold_go = 0;    // sender is in the random stream, safe to hold off
  int          words_out = 0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  id3v2_tag_frame_parser_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .file_byte_i(file_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .item_kind_o(item_kind),
    .tag_version_o(tag_version), .frame_code_o(frame_code), .known_index_o(known_index),
    .payload_length_o(payload_length), .frame_flag_bits_o(frame_flag_bits),
    .payload_byte_o(payload_byte), .frame_end_o(frame_end), .stop_cause_o(stop_cause)
  );

  id3_frame_checker i_chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .file_byte_i(file_byte),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .item_kind_o(item_kind),
    .tag_version_o(tag_version), .frame_code_o(frame_code), .known_index_o(known_index),
    .payload_length_o(payload_length), .frame_flag_bits_o(frame_flag_bits),
    .payload_byte_o(payload_byte), .frame_end_o(frame_end), .stop_cause_o(stop_cause),
    .err_cnt_o(err_cnt), .pend_cnt_o(pend_cnt)
  );

  // Watchdog: any cycle without a word moving counts toward the limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Consumer: random hold-off per word, burst stretches, and one long hold-off
  // while the sender streams, so the result queue fills and the parser stalls.
  initial begin
    int  n;
    bit  long_done;
    bit  stalled;
    long_done = 0;
    @(posedge rst_n);
    forever begin
      n = recv_burst ? 0 : $urandom_range(0, 14);
      if (!long_done && hold_go) begin
        n = 400;
        long_done = 1;
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do begin
        @(negedge clk);
        stalled = !out_valid;
        @(posedge clk);
      end while (stalled);
      words_out++;
      if (words_out % 150 == 0) recv_burst = !recv_burst;
    end
  end

  // Send one file byte; valid stays up between back-to-back words.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    bit stalled;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1;
    file_byte <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    file_pos++;
    if (file_pos % 170 == 0) send_burst = !send_burst;
  endtask

  task automatic put_word32(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8]);
  endtask

  // Let every expected word drain, then wait out DRAIN_WAIT for skip bytes still inside.
  task automatic quiesce();
    in_valid <= 0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_flen(input logic [31:0] v);
    cfg_we    <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 0;
    flen = v;
  endtask

  function automatic logic [31:0] to_syncsafe(input logic [27:0] v);
    return {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
  endfunction

  // Build the header of one frame and send it with its body.
  // kind: 0 known id, 1 unknown id, 2 skipped by flags, 3 dropped group/length bytes
  task automatic put_frame(input int kind, input int size_hint);
    logic [31:0] code, csz, sz_field;
    logic [15:0] fl;
    int          idx;
    if (kind == 1) begin
      code = {8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h30, 8'h5A)),
              8'($urandom_range(8'h30, 8'h5A)), 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 3) == 0) code = $urandom | 32'h0100_0000;
    end else if (ver == 3'd2) begin
      code = id_rom(7'($urandom_range(0, 41)));
    end else begin
      code = id_rom(7'($urandom_range(42, ROM_COUNT - 1)));
      // a three-letter id inside a four-letter tag is not a match
      if (kind == 0 && $urandom_range(0, 15) == 0) code = id_rom(7'($urandom_range(0, 41)));
    end
    fl = 16'($urandom);
    if (ver == 3'd3) begin
      fl &= 16'hFF1F;
      if (kind == 2) fl[7:6] = 2'($urandom_range(1, 3));
      if (kind == 3) fl[5] = 1;
    end else if (ver == 3'd4) begin
      fl &= 16'hFFB0;
      if (kind == 2) fl[3:1] = 3'($urandom_range(1, 7));
      if (kind == 3) begin
        fl[6] = 1'($urandom);
        fl[0] = !fl[6] || $urandom_range(0, 1);
      end
    end
    csz = (size_hint > 0) ? size_hint : $urandom_range(1, 16);
    if (kind == 3 && csz < 6) csz = $urandom_range(6, 20);
    if (ver == 3'd2) begin
      put_byte(code[31:24]); put_byte(code[23:16]); put_byte(code[15:8]);
      put_byte(csz[23:16]); put_byte(csz[15:8]); put_byte(csz[7:0]);
    end else begin
      sz_field = csz;
      // syncsafe ignores bit 7 of each size byte, so set those at random
      if (ver == 3'd4) sz_field = to_syncsafe(csz[27:0]) | ($urandom & 32'h8080_8080);
      put_word32(code);
      put_word32(sz_field);
      put_byte(fl[15:8]); put_byte(fl[7:0]);
    end
    repeat (csz) put_byte(8'($urandom));
  endtask

  initial begin
    int          n, k, sz;
    logic [7:0]  tflags;
    logic [31:0] tsize;
    ver = 3'($urandom_range(2, 4));
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    write_flen(32'hFFFF_FFFF);

    // tag header: large tag so the frame stream never reaches the tag end
    put_byte(8'h49); put_byte(8'h44); put_byte(8'h33);
    put_byte(8'(ver)); put_byte(8'($urandom));
    tflags = 8'($urandom);
    if (ver != 3'd2) tflags &= 8'h5F;
    put_byte(tflags);
    tsize = {1'b0, 7'($urandom_range(8'h40, 8'h7F)), 1'b0, 7'($urandom),
             1'b0, 7'($urandom), 1'b0, 7'($urandom)} | ($urandom & 32'h8080_8080);
    put_word32(tsize);

    // extended header and its skipped tail
    if (ver == 3'd3 && tflags[6]) begin
      n = $urandom_range(0, 10);
      put_word32(n);
      put_byte(8'($urandom)); put_byte(8'($urandom));
      put_word32($urandom_range(0, 1000));   // padding, well below the tag length
      repeat (n > 6 ? n - 6 : 0) put_byte(8'($urandom));
    end else if (ver == 3'd4 && tflags[6]) begin
      n = $urandom_range(0, 10);
      put_word32(to_syncsafe(28'(n)));
      repeat (n > 4 ? n - 4 : 0) put_byte(8'($urandom));
    end

    // directed: each frame kind, smallest and larger bodies
    put_frame(0, 1);
    put_frame(0, 2);
    put_frame(1, 3);
    put_frame(2, 4);
    put_frame(3, 0);
    put_frame(0, 40);

    // frame that exactly fits the file length
    quiesce();
    sz = $urandom_range(1, 12);
    write_flen(file_pos + ((ver == 3'd2) ? 6 : 10) + sz);
    put_frame(0, sz);
    quiesce();
    write_flen(32'hFFFF_FFFF);

    // random frames, file length rewritten every so often
    k = 0;
    while (file_pos < NUM_BYTES) begin
      n = $urandom_range(0, 9);
      put_frame(n < 6 ? 0 : (n < 7 ? 1 : (n < 8 ? 2 : 3)),
                ($urandom_range(0, 30) == 0) ? $urandom_range(60, 200) : 0);
      if (k == 2) hold_go = 1;
      if (++k % 20 == 0) begin
        quiesce();
        write_flen($urandom_range(file_pos + 32'h10000, 32'hFFFF_FFF0));
      end
    end

    // finish with a stop: zero length file or a padding byte, then ignored bytes
    quiesce();
    write_flen(32'd0);
    if ($urandom_range(0, 1)) put_byte(8'h00);
    else put_frame(0, 1);
    repeat (10) put_byte(8'($urandom));
    in_valid <= 0;

    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
